@@ rtl/tcc_pkg.sv @@
// Shared types and constants of the touch click classifier.
package tcc_pkg;

  localparam int COORD_BITS = 13;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int SUM_BITS = 16;
  localparam int RADIUS_BITS = 13;

  // Input commands
  localparam logic [3:0] CMD_START   = 4'd0;
  localparam logic [3:0] CMD_P1_DOWN = 4'd1;
  localparam logic [3:0] CMD_P1_MOVE = 4'd2;
  localparam logic [3:0] CMD_P1_UP   = 4'd3;
  localparam logic [3:0] CMD_P2_DOWN = 4'd4;
  localparam logic [3:0] CMD_P2_MOVE = 4'd5;
  localparam logic [3:0] CMD_P2_UP   = 4'd6;
  localparam logic [3:0] CMD_CANCEL  = 4'd7;
  localparam logic [3:0] CMD_TICK    = 4'd8;

  // Result actions
  localparam logic [2:0] ACT_CLICK      = 3'd0;
  localparam logic [2:0] ACT_LONG       = 3'd1;
  localparam logic [2:0] ACT_DOUBLE     = 3'd2;
  localparam logic [2:0] ACT_DUAL       = 3'd3;
  localparam logic [2:0] ACT_SINGLE     = 3'd4;
  localparam logic [2:0] ACT_START_DUAL = 3'd5;

  // Gesture modes
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_LONG   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;
  localparam logic [1:0] MODE_DUAL   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_DETECT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_TOL      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_RADIUS = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DUAL_BEGIN    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DUAL_END      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DOUBLE_MAX    = 3'd6;

  // Configuration reset values
  localparam logic [15:0] RST_MOVE_TOL      = 16'd32;
  localparam logic [12:0] RST_DOUBLE_RADIUS = 13'd208;
  localparam logic [15:0] RST_LONG_TICKS    = 16'd400;
  localparam logic [15:0] RST_DUAL_BEGIN    = 16'd100;
  localparam logic [15:0] RST_DUAL_END      = 16'd300;
  localparam logic [15:0] RST_DOUBLE_MAX    = 16'd400;

  typedef struct packed {
    logic [3:0]            cmd;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
  } tcc_in_t;

  typedef struct packed {
    logic [2:0]            action;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic                  last;
  } tcc_out_t;

  typedef struct packed {
    logic                   click_detect;
    logic [SUM_BITS-1:0]    move_tolerance_px;
    logic [RADIUS_BITS-1:0] double_radius_px;
    logic [15:0]            long_click_ticks;
    logic [15:0]            dual_begin_ticks;
    logic [15:0]            dual_end_ticks;
    logic [15:0]            double_max_ticks;
  } tcc_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } tcc_point_t;

  typedef struct packed {
    logic                running;
    logic                detect_on;
    logic [1:0]          mode;
    logic [1:0]          held;
    tcc_point_t          first_down;
    tcc_point_t          first_moved;
    logic [SUM_BITS-1:0] first_sum;
    tcc_point_t          second_down;
    tcc_point_t          second_moved;
    logic [SUM_BITS-1:0] second_sum;
  } tcc_state_t;

  // Results of one transaction: count and up to two items in order
  typedef struct packed {
    logic [1:0] count;
    tcc_out_t   res0;
    tcc_out_t   res1;
  } tcc_res_t;

endpackage

@@ rtl/touch_click_classifier_core.sv @@
// Top level of the touch click classifier: state, config and result queue.
//
//  channel | signals                          | accepted when
//  --------+----------------------------------+--------------------------
//  input   | in_valid, in_ready, in_data      | in_valid && in_ready
//  result  | out_valid, out_ready, out_data   | out_valid && out_ready
//  config  | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// Each input transaction updates the gesture state in the cycle it is accepted;
// its zero, one or two results enter a four-entry result queue at the same edge.
// The queue drains one result per cycle while out_ready is high; items with at most one result
// can be taken every cycle while results are taken, but a run of two-result items cannot.
// in_ready drops while fewer than two slots are free.
// Each result reaches out_data once the results queued before it have been taken.
// Synchronous active-low reset clears the state and the queue and loads config defaults.
module touch_click_classifier_core #(
  parameter int TIME_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  tcc_pkg::tcc_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output tcc_pkg::tcc_out_t                      out_data,
  input  logic                                   cfg_we,
  input  logic [tcc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tcc_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  tcc_pkg::tcc_cfg_t   cfg_r;
  tcc_pkg::tcc_state_t st_r, st_nxt;
  logic [TIME_BITS-1:0] el_r, el_nxt;
  tcc_pkg::tcc_res_t   res;

  tcc_pkg::tcc_out_t   oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]    wp_r, rp_r;
  logic [OQ_AW:0]      cnt_r;
  logic                in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  tcc_step #(.TIME_BITS(TIME_BITS)) u_step (
    .cfg_i (cfg_r),
    .st_i  (st_r),
    .el_i  (el_r),
    .in_i  (in_data),
    .st_o  (st_nxt),
    .el_o  (el_nxt),
    .res_o (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_detect      <= 1'b1;
      cfg_r.move_tolerance_px <= tcc_pkg::RST_MOVE_TOL;
      cfg_r.double_radius_px  <= tcc_pkg::RST_DOUBLE_RADIUS;
      cfg_r.long_click_ticks  <= tcc_pkg::RST_LONG_TICKS;
      cfg_r.dual_begin_ticks  <= tcc_pkg::RST_DUAL_BEGIN;
      cfg_r.dual_end_ticks    <= tcc_pkg::RST_DUAL_END;
      cfg_r.double_max_ticks  <= tcc_pkg::RST_DOUBLE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        tcc_pkg::CFG_CLICK_DETECT:  cfg_r.click_detect      <= cfg_wdata[0];
        tcc_pkg::CFG_MOVE_TOL:      cfg_r.move_tolerance_px <= cfg_wdata;
        tcc_pkg::CFG_DOUBLE_RADIUS:
          cfg_r.double_radius_px <= cfg_wdata[tcc_pkg::RADIUS_BITS-1:0];
        tcc_pkg::CFG_LONG_TICKS:    cfg_r.long_click_ticks  <= cfg_wdata;
        tcc_pkg::CFG_DUAL_BEGIN:    cfg_r.dual_begin_ticks  <= cfg_wdata;
        tcc_pkg::CFG_DUAL_END:      cfg_r.dual_end_ticks    <= cfg_wdata;
        tcc_pkg::CFG_DOUBLE_MAX:    cfg_r.double_max_ticks  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
      el_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
      el_r <= el_nxt;
    end
  end

  // Result queue: push up to two results, pop one
  always_ff @(posedge clk) begin
    if (in_acc && res.count != 2'd0) begin
      oq_mem[wp_r] <= res.res0;
    end
    if (in_acc && res.count == 2'd2) begin
      oq_mem[wp_r + OQ_AW'(1)] <= res.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_acc) begin
        wp_r <= wp_r + OQ_AW'(res.count);
      end
      if (out_acc) begin
        rp_r <= rp_r + OQ_AW'(1);
      end
      cnt_r <= cnt_r + (in_acc ? (OQ_AW+1)'(res.count) : '0) -
               (out_acc ? (OQ_AW+1)'(1) : '0);
    end
  end

  assign in_ready  = cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = oq_mem[rp_r];

endmodule

@@ rtl/tcc_step.sv @@
// Next-state and result logic of the classifier for one input transaction.
module tcc_step #(
  parameter int TIME_BITS = 16
) (
  input  tcc_pkg::tcc_cfg_t   cfg_i,
  input  tcc_pkg::tcc_state_t st_i,
  input  logic [TIME_BITS-1:0] el_i,
  input  tcc_pkg::tcc_in_t    in_i,
  output tcc_pkg::tcc_state_t st_o,
  output logic [TIME_BITS-1:0] el_o,
  output tcc_pkg::tcc_res_t   res_o
);

  localparam int TW = (TIME_BITS > 16) ? TIME_BITS : 16;
  localparam int CB = tcc_pkg::COORD_BITS;
  localparam int SB = tcc_pkg::SUM_BITS;

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SB-1:0] add_move(input logic [SB-1:0] sum,
                                             input tcc_pkg::tcc_point_t from,
                                             input tcc_pkg::tcc_point_t to);
    logic [SB+1:0] s;
    s = (SB+2)'(sum) + (SB+2)'(abs_diff(to.x, from.x)) + (SB+2)'(abs_diff(to.y, from.y));
    return (s > (SB+2)'({SB{1'b1}})) ? {SB{1'b1}} : s[SB-1:0];
  endfunction

  tcc_pkg::tcc_state_t mid;
  tcc_pkg::tcc_point_t p;
  logic [TIME_BITS-1:0] el_mid;
  logic                 fin;
  logic                 canc;
  logic [CB-1:0]        dx, dy;
  logic [2*CB-1:0]      dx2, dy2;
  logic [2*CB:0]        dist2;
  logic [2*tcc_pkg::RADIUS_BITS-1:0] r2;
  logic                 hit;
  logic [SB-1:0]        fsum_new, ssum_new;
  logic [1:0]           held_inc, held_dec;

  assign p.x = in_i.pos_x;
  assign p.y = in_i.pos_y;

  // Double-click distance against the stored first-down position
  assign dx    = abs_diff(p.x, st_i.first_down.x);
  assign dy    = abs_diff(p.y, st_i.first_down.y);
  assign dx2   = dx * dx;
  assign dy2   = dy * dy;
  assign dist2 = (2*CB+1)'(dx2) + (2*CB+1)'(dy2);
  assign r2    = cfg_i.double_radius_px * cfg_i.double_radius_px;
  assign hit   = (st_i.mode == tcc_pkg::MODE_DOUBLE) &&
                 (dist2 < (2*CB+1)'(r2));

  assign fsum_new = add_move(st_i.first_sum, st_i.first_moved, p);
  assign ssum_new = add_move(st_i.second_sum, st_i.second_moved, p);
  assign held_inc = (st_i.held != 2'd3) ? st_i.held + 2'd1 : st_i.held;
  assign held_dec = (st_i.held != 2'd0) ? st_i.held - 2'd1 : st_i.held;

  always_comb begin
    mid    = st_i;
    el_mid = el_i;
    fin    = 1'b0;
    canc   = 1'b0;
    if (in_i.cmd == tcc_pkg::CMD_START) begin
      if (!st_i.running) begin
        mid.detect_on  = cfg_i.click_detect;
        el_mid         = '0;
        mid.mode       = tcc_pkg::MODE_LONG;
        mid.held       = 2'd0;
        mid.first_sum  = '0;
        mid.second_sum = '0;
        mid.running    = 1'b1;
      end
    end else if (st_i.running) begin
      case (in_i.cmd)
        tcc_pkg::CMD_P1_DOWN: begin
          mid.held        = held_inc;
          mid.first_down  = p;
          mid.first_moved = p;
          mid.first_sum   = '0;
          fin             = hit;
        end
        tcc_pkg::CMD_P1_MOVE: begin
          mid.first_sum   = fsum_new;
          mid.first_moved = p;
          canc            = 1'b1;
          fin = (fsum_new >= cfg_i.move_tolerance_px) &&
                ((st_i.mode == tcc_pkg::MODE_LONG) ||
                 (st_i.mode == tcc_pkg::MODE_DUAL && st_i.held == 2'd2));
        end
        tcc_pkg::CMD_P1_UP: begin
          mid.held = held_dec;
          if (st_i.mode == tcc_pkg::MODE_LONG) begin
            mid.mode = tcc_pkg::MODE_DOUBLE;
          end else if (st_i.mode == tcc_pkg::MODE_DUAL && held_dec == 2'd0) begin
            fin = 1'b1;
          end
        end
        tcc_pkg::CMD_P2_DOWN: begin
          mid.held         = held_inc;
          mid.second_down  = p;
          mid.second_moved = p;
          mid.second_sum   = '0;
          mid.mode         = tcc_pkg::MODE_DUAL;
          canc             = 1'b1;
          fin              = TW'(el_i) > TW'(cfg_i.dual_begin_ticks);
        end
        tcc_pkg::CMD_P2_MOVE: begin
          mid.second_sum   = ssum_new;
          mid.second_moved = p;
          canc             = 1'b1;
          fin = (st_i.mode == tcc_pkg::MODE_DUAL) && (st_i.held == 2'd2) &&
                (ssum_new >= cfg_i.move_tolerance_px);
        end
        tcc_pkg::CMD_P2_UP: begin
          mid.held = held_dec;
        end
        tcc_pkg::CMD_CANCEL: begin
          mid.mode = tcc_pkg::MODE_NONE;
          fin      = 1'b1;
        end
        tcc_pkg::CMD_TICK: begin
          if (el_i != {TIME_BITS{1'b1}}) begin
            el_mid = el_i + 1'b1;
          end
          case (st_i.mode)
            tcc_pkg::MODE_LONG: begin
              fin = !st_i.detect_on || (TW'(el_mid) >= TW'(cfg_i.long_click_ticks));
            end
            tcc_pkg::MODE_DOUBLE: begin
              canc = 1'b1;
              fin  = !st_i.detect_on || (TW'(el_mid) >= TW'(cfg_i.double_max_ticks));
            end
            tcc_pkg::MODE_DUAL: begin
              canc = 1'b1;
              fin  = !st_i.detect_on || (TW'(el_mid) >= TW'(cfg_i.dual_end_ticks));
            end
            default: fin = 1'b1;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Decision results from the updated state, then go idle
  always_comb begin
    res_o = '0;
    st_o  = mid;
    el_o  = el_mid;
    if (fin) begin
      st_o.running = 1'b0;
      st_o.mode    = tcc_pkg::MODE_NONE;
      case (mid.mode)
        tcc_pkg::MODE_LONG: begin
          res_o.count = 2'd1;
          if (!mid.detect_on) begin
            res_o.count        = 2'd2;
            res_o.res0.action  = tcc_pkg::ACT_SINGLE;
            res_o.res0.first_x = mid.first_moved.x;
            res_o.res0.first_y = mid.first_moved.y;
            res_o.res1.action  = tcc_pkg::ACT_CLICK;
            res_o.res1.first_x = mid.first_down.x;
            res_o.res1.first_y = mid.first_down.y;
            res_o.res1.last    = 1'b1;
          end else if (canc) begin
            res_o.res0.action  = tcc_pkg::ACT_SINGLE;
            res_o.res0.first_x = mid.first_moved.x;
            res_o.res0.first_y = mid.first_moved.y;
            res_o.res0.last    = 1'b1;
          end else begin
            res_o.res0.action  = tcc_pkg::ACT_LONG;
            res_o.res0.first_x = mid.first_down.x;
            res_o.res0.first_y = mid.first_down.y;
            res_o.res0.last    = 1'b1;
          end
        end
        tcc_pkg::MODE_DOUBLE: begin
          res_o.count        = 2'd1;
          res_o.res0.action  = canc ? tcc_pkg::ACT_CLICK : tcc_pkg::ACT_DOUBLE;
          res_o.res0.first_x = mid.first_down.x;
          res_o.res0.first_y = mid.first_down.y;
          res_o.res0.last    = 1'b1;
        end
        tcc_pkg::MODE_DUAL: begin
          res_o.res0.last = 1'b1;
          if (!canc) begin
            res_o.count         = 2'd1;
            res_o.res0.action   = tcc_pkg::ACT_DUAL;
            res_o.res0.first_x  = mid.first_down.x;
            res_o.res0.first_y  = mid.first_down.y;
            res_o.res0.second_x = mid.second_down.x;
            res_o.res0.second_y = mid.second_down.y;
          end else if (mid.held == 2'd1) begin
            res_o.count        = 2'd1;
            res_o.res0.action  = tcc_pkg::ACT_SINGLE;
            res_o.res0.first_x = mid.first_moved.x;
            res_o.res0.first_y = mid.first_moved.y;
          end else if (mid.held != 2'd0) begin
            res_o.count         = 2'd1;
            res_o.res0.action   = tcc_pkg::ACT_START_DUAL;
            res_o.res0.first_x  = mid.first_moved.x;
            res_o.res0.first_y  = mid.first_moved.y;
            res_o.res0.second_x = mid.second_moved.x;
            res_o.res0.second_y = mid.second_moved.y;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/tcc_chk.sv @@
// Port checker for the touch click classifier, bound to the top level.
module tcc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input tcc_pkg::tcc_out_t out_data
);

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_stall_has_results: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result queued");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.action <= tcc_pkg::ACT_START_DUAL)
    else $error("action code out of range");

  a_single_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action != tcc_pkg::ACT_DUAL &&
     out_data.action != tcc_pkg::ACT_START_DUAL)
    |-> (out_data.second_x == '0 && out_data.second_y == '0))
    else $error("second pointer set on a single-pointer action");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

endmodule

bind touch_click_classifier_core tcc_chk u_tcc_chk (.*);

@@ tb/tb.sv @@
// Testbench of the touch click classifier core: scripted gestures, then random ones.
`timescale 1ns / 100ps

module tb;
  import tcc_pkg::*;

  // Command codes the block must ignore
  localparam logic [3:0] CMD_BOGUS_LO = 4'd9;
  localparam logic [3:0] CMD_BOGUS_HI = 4'd15;
  localparam tcc_out_t NO_RES = '0;

  typedef struct packed {
    bit                  armed;
    bit                  detect;
    logic [1:0]          mode;
    logic [1:0]          held;
    tcc_point_t          p1_down;
    tcc_point_t          p1_now;
    tcc_point_t          p2_down;
    tcc_point_t          p2_now;
    logic [SUM_BITS-1:0] p1_travel;
    logic [SUM_BITS-1:0] p2_travel;
    logic [15:0]         ticks;
  } track_t;

  typedef struct {
    tcc_in_t  item;
    bit       pinned;
    int       n_res;
    tcc_out_t res;
  } row_t;

  typedef struct {
    tcc_cfg_t regs;
    int       burst;
    int       budget;
    int       jump;
    bit       calm;
    bit       marathon;
    bit       squeeze;
  } phase_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tcc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tcc_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  tcc_cfg_t knobs = '{1'b1, RST_MOVE_TOL, RST_DOUBLE_RADIUS, RST_LONG_TICKS,
                      RST_DUAL_BEGIN, RST_DUAL_END, RST_DOUBLE_MAX};
  track_t   gesture = '0;
  tcc_out_t verdict [2];
  tcc_out_t expected_actions [$];
  int       mismatches = 0;
  bit       calm = 1'b0;
  bit       squeeze_req = 1'b0;
  bit       squeeze_done = 1'b0;
  int       squeeze_left = 0;

  row_t script [25] = '{
    '{'{CMD_P1_DOWN, 13'd0, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_TICK, 13'd8191, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_BOGUS_HI, 13'd8191, 13'd8191}, 1'b1, 0, NO_RES},
    '{'{CMD_START, 13'd0, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_START, 13'd0, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd8191, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_BOGUS_LO, 13'd0, 13'd8191}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_MOVE, 13'd8191, 13'd31}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_MOVE, 13'd8191, 13'd32}, 1'b1, 1,
      '{ACT_SINGLE, 13'd8191, 13'd32, 13'd0, 13'd0, 1'b1}},
    '{'{CMD_CANCEL, 13'd0, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_START, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd100, 13'd100}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_UP, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd307, 13'd100}, 1'b1, 1,
      '{ACT_DOUBLE, 13'd307, 13'd100, 13'd0, 13'd0, 1'b1}},
    '{'{CMD_START, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd0, 13'd8191}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_UP, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd208, 13'd8191}, 1'b1, 0, NO_RES},
    '{'{CMD_TICK, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_CANCEL, 13'd0, 13'd0}, 1'b1, 0, NO_RES},
    '{'{CMD_START, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_DOWN, 13'd5, 13'd5}, 1'b0, 0, NO_RES},
    '{'{CMD_P2_DOWN, 13'd8191, 13'd8191}, 1'b0, 0, NO_RES},
    '{'{CMD_P2_UP, 13'd0, 13'd0}, 1'b0, 0, NO_RES},
    '{'{CMD_P1_UP, 13'd0, 13'd0}, 1'b1, 1,
      '{ACT_DUAL, 13'd5, 13'd5, 13'd8191, 13'd8191, 1'b1}}
  };

  phase_t plan [8] = '{
    '{'{1'b1, 16'd32, 13'd208, 16'd400, 16'd100, 16'd300, 16'd400},
      120, 200, 20, 1'b0, 1'b0, 1'b0},
    '{'{1'b1, 16'd40, 13'd300, 16'd12, 16'd6, 16'd20, 16'd15},
      8, 250, 20, 1'b0, 1'b0, 1'b1},
    '{'{1'b0, 16'd32, 13'd208, 16'd400, 16'd100, 16'd300, 16'd400},
      4, 150, 20, 1'b0, 1'b0, 1'b0},
    '{'{1'b1, 16'd0, 13'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      3, 120, 20, 1'b0, 1'b0, 1'b0},
    '{'{1'b1, 16'd65535, 13'd8191, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
      40, 120, 90, 1'b0, 1'b1, 1'b0},
    '{'{1'b1, 16'd65535, 13'd8191, 16'd30, 16'd10, 16'd40, 16'd25},
      10, 150, 50, 1'b0, 1'b0, 1'b0},
    '{'{1'b1, 16'd16, 13'd100, 16'd20, 16'd8, 16'd30, 16'd20},
      12, 200, 20, 1'b1, 1'b0, 1'b0},
    '{'{1'b1, 16'd1, 13'd1, 16'd5, 16'd1, 16'd10, 16'd6},
      6, 210, 20, 1'b0, 1'b0, 1'b0}
  };

  touch_click_classifier_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [SUM_BITS-1:0] travel_add(logic [SUM_BITS-1:0] sum,
                                                     tcc_point_t a, tcc_point_t b);
    int dx;
    int dy;
    int s;
    dx = (a.x > b.x) ? int'(a.x) - int'(b.x) : int'(b.x) - int'(a.x);
    dy = (a.y > b.y) ? int'(a.y) - int'(b.y) : int'(b.y) - int'(a.y);
    s = int'(sum) + dx + dy;
    return (s > 65535) ? '1 : SUM_BITS'(s);
  endfunction

  function automatic int post_action(int k, logic [2:0] act, tcc_point_t a,
                                     tcc_point_t b, bit pair);
    verdict[k].action   = act;
    verdict[k].first_x  = a.x;
    verdict[k].first_y  = a.y;
    verdict[k].second_x = pair ? b.x : '0;
    verdict[k].second_y = pair ? b.y : '0;
    verdict[k].last     = 1'b0;
    return k + 1;
  endfunction

  // Close the gesture: results for the current mode, then go idle.
  function automatic int settle_gesture(bit dropped);
    int n;
    tcc_point_t none;
    n = 0;
    none = '0;
    case (gesture.mode)
      MODE_LONG: begin
        if (!gesture.detect) begin
          n = post_action(n, ACT_SINGLE, gesture.p1_now, none, 1'b0);
          n = post_action(n, ACT_CLICK, gesture.p1_down, none, 1'b0);
        end else if (dropped) begin
          n = post_action(n, ACT_SINGLE, gesture.p1_now, none, 1'b0);
        end else begin
          n = post_action(n, ACT_LONG, gesture.p1_down, none, 1'b0);
        end
      end
      MODE_DOUBLE: begin
        n = post_action(n, dropped ? ACT_CLICK : ACT_DOUBLE, gesture.p1_down, none, 1'b0);
      end
      MODE_DUAL: begin
        if (!dropped)
          n = post_action(n, ACT_DUAL, gesture.p1_down, gesture.p2_down, 1'b1);
        else if (gesture.held == 1)
          n = post_action(n, ACT_SINGLE, gesture.p1_now, none, 1'b0);
        else if (gesture.held >= 2)
          n = post_action(n, ACT_START_DUAL, gesture.p1_now, gesture.p2_now, 1'b1);
      end
      default: ;
    endcase
    if (n > 0) verdict[n-1].last = 1'b1;
    gesture.armed = 1'b0;
    gesture.mode = MODE_NONE;
    return n;
  endfunction

  // Advance the gesture tracker by one transaction; returns the result count.
  function automatic int classify_item(tcc_in_t it);
    tcc_point_t p;
    longint dx;
    longint dy;
    longint r;
    bit hit;
    p.x = it.pos_x;
    p.y = it.pos_y;
    if (it.cmd == CMD_START) begin
      if (!gesture.armed) begin
        gesture.detect = knobs.click_detect;
        gesture.ticks = '0;
        gesture.mode = MODE_LONG;
        gesture.held = '0;
        gesture.p1_travel = '0;
        gesture.p2_travel = '0;
        gesture.armed = 1'b1;
      end
      return 0;
    end
    if (!gesture.armed) return 0;
    case (it.cmd)
      CMD_P1_DOWN: begin
        if (gesture.held != '1) gesture.held++;
        hit = 1'b0;
        if (gesture.mode == MODE_DOUBLE) begin
          dx = (p.x > gesture.p1_down.x) ? p.x - gesture.p1_down.x : gesture.p1_down.x - p.x;
          dy = (p.y > gesture.p1_down.y) ? p.y - gesture.p1_down.y : gesture.p1_down.y - p.y;
          r = knobs.double_radius_px;
          hit = dx * dx + dy * dy < r * r;
        end
        gesture.p1_down = p;
        gesture.p1_now = p;
        gesture.p1_travel = '0;
        return hit ? settle_gesture(1'b0) : 0;
      end
      CMD_P1_MOVE: begin
        gesture.p1_travel = travel_add(gesture.p1_travel, gesture.p1_now, p);
        gesture.p1_now = p;
        if (gesture.p1_travel >= knobs.move_tolerance_px &&
            (gesture.mode == MODE_LONG || (gesture.mode == MODE_DUAL && gesture.held == 2)))
          return settle_gesture(1'b1);
        return 0;
      end
      CMD_P1_UP: begin
        if (gesture.held != 0) gesture.held--;
        if (gesture.mode == MODE_LONG)
          gesture.mode = MODE_DOUBLE;
        else if (gesture.mode == MODE_DUAL && gesture.held == 0)
          return settle_gesture(1'b0);
        return 0;
      end
      CMD_P2_DOWN: begin
        if (gesture.held != '1) gesture.held++;
        gesture.p2_down = p;
        gesture.p2_now = p;
        gesture.p2_travel = '0;
        gesture.mode = MODE_DUAL;
        if (gesture.ticks > knobs.dual_begin_ticks) return settle_gesture(1'b1);
        return 0;
      end
      CMD_P2_MOVE: begin
        gesture.p2_travel = travel_add(gesture.p2_travel, gesture.p2_now, p);
        gesture.p2_now = p;
        if (gesture.mode == MODE_DUAL && gesture.p2_travel >= knobs.move_tolerance_px &&
            gesture.held == 2)
          return settle_gesture(1'b1);
        return 0;
      end
      CMD_P2_UP: begin
        if (gesture.held != 0) gesture.held--;
        return 0;
      end
      CMD_CANCEL: begin
        gesture.mode = MODE_NONE;
        return settle_gesture(1'b0);
      end
      CMD_TICK: begin
        if (gesture.ticks != '1) gesture.ticks++;
        case (gesture.mode)
          MODE_LONG:
            if (!gesture.detect || gesture.ticks >= knobs.long_click_ticks)
              return settle_gesture(1'b0);
          MODE_DOUBLE:
            if (!gesture.detect || gesture.ticks >= knobs.double_max_ticks)
              return settle_gesture(1'b1);
          MODE_DUAL:
            if (!gesture.detect || gesture.ticks >= knobs.dual_end_ticks)
              return settle_gesture(1'b1);
          default:
            return settle_gesture(1'b0);
        endcase
        return 0;
      end
      default: return 0;
    endcase
    return 0;
  endfunction

  function automatic tcc_point_t jitter(tcc_point_t c, int spread);
    tcc_point_t q;
    q.x = c.x + 13'($urandom_range(0, 2 * spread)) - 13'(spread);
    q.y = c.y + 13'($urandom_range(0, 2 * spread)) - 13'(spread);
    return q;
  endfunction

  function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
    end
  endfunction

  // Predict, queue the expected results, then hold the transaction until taken.
  task automatic offer(input tcc_in_t it, input bit pinned, input int pin_n,
                       input tcc_out_t pin_res);
    int n;
    n = classify_item(it);
    if (pinned) begin
      if (pin_n > 0) expected_actions.push_back(pin_res);
    end else begin
      for (int i = 0; i < n; i++) expected_actions.push_back(verdict[i]);
    end
    if (!calm && $urandom_range(0, 99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_actions.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_settings(input tcc_cfg_t s);
    logic [CFG_INDEX_BITS-1:0] slot [7];
    logic [CFG_DATA_BITS-1:0]  word [7];
    slot = '{CFG_CLICK_DETECT, CFG_MOVE_TOL, CFG_DOUBLE_RADIUS, CFG_LONG_TICKS,
             CFG_DUAL_BEGIN, CFG_DUAL_END, CFG_DOUBLE_MAX};
    // unused upper bits carry noise; the block keeps only the register width
    word = '{{15'($urandom), s.click_detect}, s.move_tolerance_px,
             {3'($urandom), s.double_radius_px}, s.long_click_ticks,
             s.dual_begin_ticks, s.dual_end_ticks, s.double_max_ticks};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= slot[i];
      cfg_wdata <= word[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    knobs = s;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (squeeze_req && !squeeze_done) begin
      squeeze_left = 300;
      squeeze_done = 1'b1;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    tcc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actions.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with nothing expected, got %p", $time, out_data);
      end else begin
        want = expected_actions.pop_front();
        check_field("action", want.action, out_data.action);
        check_field("first_x", want.first_x, out_data.first_x);
        check_field("first_y", want.first_y, out_data.first_y);
        check_field("second_x", want.second_x, out_data.second_x);
        check_field("second_y", want.second_y, out_data.second_y);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  initial begin
    tcc_in_t it;
    tcc_point_t spot;
    int pick;
    int reps;
    int spent;
    bit wide;
    bit paused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i])
      offer(script[i].item, script[i].pinned, script[i].n_res, script[i].res);
    drain();

    foreach (plan[k]) begin
      load_settings(plan[k].regs);
      calm = plan[k].calm;
      paused = 1'b0;
      if (plan[k].marathon) begin
        // drive the travel sum into its ceiling, then hold a tap through a run of ticks
        offer('{CMD_CANCEL, 13'd0, 13'd0}, 1'b0, 0, NO_RES);
        offer('{CMD_START, 13'd0, 13'd0}, 1'b0, 0, NO_RES);
        offer('{CMD_P1_DOWN, 13'd0, 13'd0}, 1'b0, 0, NO_RES);
        for (int j = 0; gesture.armed; j++) begin
          it.cmd = CMD_P1_MOVE;
          it.pos_x = j[0] ? 13'd0 : 13'd8191;
          it.pos_y = j[0] ? 13'd0 : 13'd8191;
          offer(it, 1'b0, 0, NO_RES);
        end
        offer('{CMD_START, 13'd0, 13'd0}, 1'b0, 0, NO_RES);
        offer('{CMD_P1_DOWN, 13'd4000, 13'd4000}, 1'b0, 0, NO_RES);
        offer('{CMD_P1_UP, 13'd0, 13'd0}, 1'b0, 0, NO_RES);
        repeat (64) offer('{CMD_TICK, 13'($urandom), 13'($urandom)}, 1'b0, 0, NO_RES);
      end
      spent = 0;
      while (spent < plan[k].budget) begin
        if (plan[k].squeeze && spent >= 40) squeeze_req = 1'b1;
        if (plan[k].squeeze && spent >= 160 && !paused) begin
          drain();
          paused = 1'b1;
        end
        reps = 1;
        if (!gesture.armed) begin
          it.cmd = ($urandom_range(0, 99) < 85) ? CMD_START
                   : 4'($urandom_range(CMD_START, CMD_BOGUS_HI));
          it.pos_x = 13'($urandom);
          it.pos_y = 13'($urandom);
        end else begin
          pick = $urandom_range(0, 99);
          wide = $urandom_range(0, 99) < plan[k].jump;
          spot.x = 13'($urandom);
          spot.y = 13'($urandom);
          if (pick < 12) begin
            it.cmd = CMD_P1_DOWN;
            if (!wide) spot = jitter(gesture.p1_down, 160);
          end else if (pick < 30) begin
            it.cmd = CMD_P1_MOVE;
            if (!wide) spot = jitter(gesture.p1_now, 10);
          end else if (pick < 42) begin
            it.cmd = CMD_P1_UP;
          end else if (pick < 50) begin
            it.cmd = CMD_P2_DOWN;
            if (!wide) spot = jitter(gesture.p1_now, 300);
          end else if (pick < 60) begin
            it.cmd = CMD_P2_MOVE;
            if (!wide) spot = jitter(gesture.p2_now, 10);
          end else if (pick < 67) begin
            it.cmd = CMD_P2_UP;
          end else if (pick < 69) begin
            it.cmd = CMD_CANCEL;
          end else if (pick < 71) begin
            it.cmd = CMD_START;
          end else if (pick < 73) begin
            it.cmd = 4'($urandom_range(CMD_BOGUS_LO, CMD_BOGUS_HI));
          end else begin
            it.cmd = CMD_TICK;
            reps = $urandom_range(1, plan[k].burst);
          end
          it.pos_x = spot.x;
          it.pos_y = spot.y;
        end
        // stop a tick burst once the gesture has been decided
        for (int j = 0; j < reps && (j == 0 || gesture.armed); j++) begin
          if (gesture.armed ? (it.cmd != CMD_START && it.cmd <= CMD_TICK)
                            : (it.cmd == CMD_START))
            spent++;
          offer(it, 1'b0, 0, NO_RES);
        end
      end
      drain();
    end

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tcc_pkg.sv
rtl/tcc_step.sv
rtl/touch_click_classifier_core.sv
rtl/tcc_chk.sv
tb/tb.sv
